// ===== src/weighted_access_point_selector_core_macros.svh =====
// Assertion macros shared by the checker of the access point selector.
`ifndef WEIGHTED_ACCESS_POINT_SELECTOR_CORE_MACROS_SVH
`define WEIGHTED_ACCESS_POINT_SELECTOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("selector check failed");

// Consequent must hold in the cycle after the antecedent.
`define WAPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("selector check failed");

`endif

// ===== src/waps_pkg.sv =====
// Package with the types, codes and constants of the access point selector.
`timescale 1ns / 1ps
package waps_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_THRESH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_TPUT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_DIST  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_CHAN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_USERS = 3'd5;

   localparam logic [4:0]  RST_ACTIVE_COUNT = 5'd5;
   localparam logic [15:0] RST_DIST_THRESH  = 16'd6400;
   localparam logic [15:0] RST_WEIGHT_TPUT  = 16'd26214;
   localparam logic [15:0] RST_WEIGHT_DIST  = 16'd19661;
   localparam logic [15:0] RST_WEIGHT_CHAN  = 16'd13107;
   localparam logic [15:0] RST_WEIGHT_USERS = 16'd6554;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   // One in Q1.16 score format.
   localparam logic [16:0] SCORE_ONE = 17'h10000;

   typedef struct packed {
      logic        operation;
      logic [3:0]  ap_index;
      logic [15:0] ap_x;
      logic [15:0] ap_y;
      logic [7:0]  ap_users;
      logic [15:0] ap_utilization;
      logic [7:0]  ap_rate_count;
      logic [23:0] ap_inverse_rate_sum;
      logic [15:0] user_x;
      logic [15:0] user_y;
      logic [15:0] user_id;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  selected_ap;
      logic [15:0] result_user_id;
      logic [17:0] best_score;
      logic [15:0] best_distance;
      logic [15:0] expected_throughput;
   } rsp_type;

   typedef enum logic [5:0] {
      DP_NONE, DP_WRITE, DP_LOAD, DP_THR, DP_THR_SAVE, DP_DX, DP_DY, DP_SUM, DP_TEST,
      DP_SQRT_INIT, DP_SQRT_STEP, DP_TP_MUL1, DP_TP_MUL2, DP_TP_NUM, DP_TP_DIRECT,
      DP_TP_DIV_INIT, DP_DIV_STEP, DP_TP_SAVE, DP_P1_STORE, DP_NEXT, DP_IDX_CLEAR,
      DP_ST_INIT, DP_ST_SAVE, DP_SD_INIT, DP_SD_SAVE, DP_SU_INIT, DP_SU_SAVE,
      DP_W_T, DP_W_D, DP_W_C, DP_W_U, DP_W_SUM, DP_CMP, DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic at_end;
      logic cand_now;
      logic cand_sel;
      logic rate_zero;
      logic tp_ovf;
      logic iter_last;
      logic any;
      logic t_flat;
      logic d_flat;
      logic u_zero;
      logic rsp_free;
   } dp_status_type;

   typedef enum logic [5:0] {
      S_IDLE, S_THR, S_THR_SAVE, S_P1_READ, S_P1_DX, S_P1_DY, S_P1_SUM, S_P1_TEST,
      S_SQRT_INIT, S_SQRT_STEP, S_TP_MUL1, S_TP_MUL2, S_TP_NUM, S_TP_CHK, S_TP_DIRECT,
      S_TP_DIV_INIT, S_TP_DIV, S_TP_SAVE, S_P1_STORE, S_P1_NEXT, S_P2_START, S_P2_READ,
      S_SCT_INIT, S_SCT_DIV, S_SCT_SAVE, S_SCD_INIT, S_SCD_DIV, S_SCD_SAVE,
      S_SCU_INIT, S_SCU_DIV, S_SCU_SAVE, S_W_T, S_W_D, S_W_C, S_W_U, S_W_SUM,
      S_CMP, S_P2_NEXT, S_RESULT
   } ctl_state_type;

   // Link rate in Mbps Q8.8 from the squared distance (Q16.16 square metres).
   function automatic logic [15:0] rate_for(input logic [32:0] s);
      if (s < 33'd1638400) begin
         return 16'd38400;
      end else if (s < 33'd6553600) begin
         return 16'd33280;
      end else if (s < 33'd14745600) begin
         return 16'd25600;
      end else if (s < 33'd26214400) begin
         return 16'd16640;
      end else if (s < 33'd40960000) begin
         return 16'd7680;
      end
      return 16'd1664;
   endfunction

endpackage

// ===== src/waps_controller.sv =====
// Sequencer that steps the selector datapath through both passes over the entries.
`timescale 1ns / 1ps
module waps_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   output waps_pkg::dp_cmd_type    cmd,
   input  waps_pkg::dp_status_type status
);

   waps_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= waps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         waps_pkg::S_IDLE: begin
            if (req_valid && req_operation == waps_pkg::REQ_SELECT) begin
               state_in = waps_pkg::S_THR;
            end
         end
         waps_pkg::S_THR:       state_in = waps_pkg::S_THR_SAVE;
         waps_pkg::S_THR_SAVE:  state_in = waps_pkg::S_P1_READ;
         waps_pkg::S_P1_READ: begin
            if (!status.at_end) begin
               state_in = waps_pkg::S_P1_DX;
            end else if (status.any) begin
               state_in = waps_pkg::S_P2_START;
            end else begin
               state_in = waps_pkg::S_RESULT;
            end
         end
         waps_pkg::S_P1_DX:     state_in = waps_pkg::S_P1_DY;
         waps_pkg::S_P1_DY:     state_in = waps_pkg::S_P1_SUM;
         waps_pkg::S_P1_SUM:    state_in = waps_pkg::S_P1_TEST;
         waps_pkg::S_P1_TEST: begin
            state_in = status.cand_now ? waps_pkg::S_SQRT_INIT : waps_pkg::S_P1_NEXT;
         end
         waps_pkg::S_SQRT_INIT: state_in = waps_pkg::S_SQRT_STEP;
         waps_pkg::S_SQRT_STEP: begin
            if (status.iter_last) begin
               state_in = status.rate_zero ? waps_pkg::S_TP_DIRECT : waps_pkg::S_TP_MUL1;
            end
         end
         waps_pkg::S_TP_MUL1:   state_in = waps_pkg::S_TP_MUL2;
         waps_pkg::S_TP_MUL2:   state_in = waps_pkg::S_TP_NUM;
         waps_pkg::S_TP_NUM:    state_in = waps_pkg::S_TP_CHK;
         waps_pkg::S_TP_CHK: begin
            state_in = status.tp_ovf ? waps_pkg::S_TP_DIRECT : waps_pkg::S_TP_DIV_INIT;
         end
         waps_pkg::S_TP_DIRECT:   state_in = waps_pkg::S_P1_STORE;
         waps_pkg::S_TP_DIV_INIT: state_in = waps_pkg::S_TP_DIV;
         waps_pkg::S_TP_DIV: begin
            if (status.iter_last) begin
               state_in = waps_pkg::S_TP_SAVE;
            end
         end
         waps_pkg::S_TP_SAVE:   state_in = waps_pkg::S_P1_STORE;
         waps_pkg::S_P1_STORE:  state_in = waps_pkg::S_P1_NEXT;
         waps_pkg::S_P1_NEXT:   state_in = waps_pkg::S_P1_READ;
         waps_pkg::S_P2_START:  state_in = waps_pkg::S_P2_READ;
         waps_pkg::S_P2_READ: begin
            if (status.at_end) begin
               state_in = waps_pkg::S_RESULT;
            end else if (status.cand_sel) begin
               state_in = waps_pkg::S_SCT_INIT;
            end else begin
               state_in = waps_pkg::S_P2_NEXT;
            end
         end
         waps_pkg::S_SCT_INIT: begin
            state_in = status.t_flat ? waps_pkg::S_SCT_SAVE : waps_pkg::S_SCT_DIV;
         end
         waps_pkg::S_SCT_DIV: begin
            if (status.iter_last) begin
               state_in = waps_pkg::S_SCT_SAVE;
            end
         end
         waps_pkg::S_SCT_SAVE:  state_in = waps_pkg::S_SCD_INIT;
         waps_pkg::S_SCD_INIT: begin
            state_in = status.d_flat ? waps_pkg::S_SCD_SAVE : waps_pkg::S_SCD_DIV;
         end
         waps_pkg::S_SCD_DIV: begin
            if (status.iter_last) begin
               state_in = waps_pkg::S_SCD_SAVE;
            end
         end
         waps_pkg::S_SCD_SAVE:  state_in = waps_pkg::S_SCU_INIT;
         waps_pkg::S_SCU_INIT: begin
            state_in = status.u_zero ? waps_pkg::S_SCU_SAVE : waps_pkg::S_SCU_DIV;
         end
         waps_pkg::S_SCU_DIV: begin
            if (status.iter_last) begin
               state_in = waps_pkg::S_SCU_SAVE;
            end
         end
         waps_pkg::S_SCU_SAVE:  state_in = waps_pkg::S_W_T;
         waps_pkg::S_W_T:       state_in = waps_pkg::S_W_D;
         waps_pkg::S_W_D:       state_in = waps_pkg::S_W_C;
         waps_pkg::S_W_C:       state_in = waps_pkg::S_W_U;
         waps_pkg::S_W_U:       state_in = waps_pkg::S_W_SUM;
         waps_pkg::S_W_SUM:     state_in = waps_pkg::S_CMP;
         waps_pkg::S_CMP:       state_in = waps_pkg::S_P2_NEXT;
         waps_pkg::S_P2_NEXT:   state_in = waps_pkg::S_P2_READ;
         waps_pkg::S_RESULT: begin
            if (status.rsp_free) begin
               state_in = waps_pkg::S_IDLE;
            end
         end
         default:               state_in = waps_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = waps_pkg::DP_NONE;
      case (state_ff)
         waps_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = (req_operation == waps_pkg::REQ_WRITE) ? waps_pkg::DP_WRITE
                                                               : waps_pkg::DP_LOAD;
            end
         end
         waps_pkg::S_THR:         cmd.op = waps_pkg::DP_THR;
         waps_pkg::S_THR_SAVE:    cmd.op = waps_pkg::DP_THR_SAVE;
         waps_pkg::S_P1_DX:       cmd.op = waps_pkg::DP_DX;
         waps_pkg::S_P1_DY:       cmd.op = waps_pkg::DP_DY;
         waps_pkg::S_P1_SUM:      cmd.op = waps_pkg::DP_SUM;
         waps_pkg::S_P1_TEST:     cmd.op = waps_pkg::DP_TEST;
         waps_pkg::S_SQRT_INIT:   cmd.op = waps_pkg::DP_SQRT_INIT;
         waps_pkg::S_SQRT_STEP:   cmd.op = waps_pkg::DP_SQRT_STEP;
         waps_pkg::S_TP_MUL1:     cmd.op = waps_pkg::DP_TP_MUL1;
         waps_pkg::S_TP_MUL2:     cmd.op = waps_pkg::DP_TP_MUL2;
         waps_pkg::S_TP_NUM:      cmd.op = waps_pkg::DP_TP_NUM;
         waps_pkg::S_TP_DIRECT:   cmd.op = waps_pkg::DP_TP_DIRECT;
         waps_pkg::S_TP_DIV_INIT: cmd.op = waps_pkg::DP_TP_DIV_INIT;
         waps_pkg::S_TP_DIV:      cmd.op = waps_pkg::DP_DIV_STEP;
         waps_pkg::S_TP_SAVE:     cmd.op = waps_pkg::DP_TP_SAVE;
         waps_pkg::S_P1_STORE:    cmd.op = waps_pkg::DP_P1_STORE;
         waps_pkg::S_P1_NEXT:     cmd.op = waps_pkg::DP_NEXT;
         waps_pkg::S_P2_START:    cmd.op = waps_pkg::DP_IDX_CLEAR;
         waps_pkg::S_SCT_INIT:    cmd.op = waps_pkg::DP_ST_INIT;
         waps_pkg::S_SCT_DIV:     cmd.op = waps_pkg::DP_DIV_STEP;
         waps_pkg::S_SCT_SAVE:    cmd.op = waps_pkg::DP_ST_SAVE;
         waps_pkg::S_SCD_INIT:    cmd.op = waps_pkg::DP_SD_INIT;
         waps_pkg::S_SCD_DIV:     cmd.op = waps_pkg::DP_DIV_STEP;
         waps_pkg::S_SCD_SAVE:    cmd.op = waps_pkg::DP_SD_SAVE;
         waps_pkg::S_SCU_INIT:    cmd.op = waps_pkg::DP_SU_INIT;
         waps_pkg::S_SCU_DIV:     cmd.op = waps_pkg::DP_DIV_STEP;
         waps_pkg::S_SCU_SAVE:    cmd.op = waps_pkg::DP_SU_SAVE;
         waps_pkg::S_W_T:         cmd.op = waps_pkg::DP_W_T;
         waps_pkg::S_W_D:         cmd.op = waps_pkg::DP_W_D;
         waps_pkg::S_W_C:         cmd.op = waps_pkg::DP_W_C;
         waps_pkg::S_W_U:         cmd.op = waps_pkg::DP_W_U;
         waps_pkg::S_W_SUM:       cmd.op = waps_pkg::DP_W_SUM;
         waps_pkg::S_CMP:         cmd.op = waps_pkg::DP_CMP;
         waps_pkg::S_P2_NEXT:     cmd.op = waps_pkg::DP_NEXT;
         waps_pkg::S_RESULT: begin
            if (status.rsp_free) begin
               cmd.op = waps_pkg::DP_RESULT;
            end
         end
         default:                 cmd.op = waps_pkg::DP_NONE;
      endcase
   end

endmodule

// ===== src/waps_datapath.sv =====
// Datapath of the selector: entry stores, shared multiplier, root and divide units.
`timescale 1ns / 1ps
module waps_datapath #(
   parameter int MAX_APS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  waps_pkg::req_type                     req_payload,
   input  logic                                  csr_we,
   input  logic [waps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [waps_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  waps_pkg::dp_cmd_type                  cmd,
   output waps_pkg::dp_status_type               status,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output waps_pkg::rsp_type                     rsp_payload
);

   localparam int IDX_W = (MAX_APS > 1) ? $clog2(MAX_APS) : 1;
   localparam int CNT_W = $clog2(MAX_APS + 1);

   // Configuration registers.
   logic [4:0]  active_count_ff;
   logic [15:0] dist_thresh_ff, w_tput_ff, w_dist_ff, w_chan_ff, w_users_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= waps_pkg::RST_ACTIVE_COUNT;
         dist_thresh_ff  <= waps_pkg::RST_DIST_THRESH;
         w_tput_ff       <= waps_pkg::RST_WEIGHT_TPUT;
         w_dist_ff       <= waps_pkg::RST_WEIGHT_DIST;
         w_chan_ff       <= waps_pkg::RST_WEIGHT_CHAN;
         w_users_ff      <= waps_pkg::RST_WEIGHT_USERS;
      end else if (csr_we) begin
         case (csr_index)
            waps_pkg::CSR_ACTIVE_COUNT: active_count_ff <= csr_wdata[4:0];
            waps_pkg::CSR_DIST_THRESH:  dist_thresh_ff  <= csr_wdata;
            waps_pkg::CSR_WEIGHT_TPUT:  w_tput_ff       <= csr_wdata;
            waps_pkg::CSR_WEIGHT_DIST:  w_dist_ff       <= csr_wdata;
            waps_pkg::CSR_WEIGHT_CHAN:  w_chan_ff       <= csr_wdata;
            waps_pkg::CSR_WEIGHT_USERS: w_users_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Entry stores and per-select scratch memories.
   logic [31:0] pos_mem  [MAX_APS];
   logic [23:0] load_mem [MAX_APS];
   logic [31:0] rate_mem [MAX_APS];
   logic [15:0] dist_mem [MAX_APS];
   logic [15:0] tp_mem   [MAX_APS];
   logic [31:0] pos_rd_ff, rate_rd_ff;
   logic [23:0] load_rd_ff;
   logic [15:0] dist_rd_ff, tp_rd_ff;
   logic [MAX_APS-1:0] cand_ff;

   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] lim;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic             wr_ok;

   // Working registers.
   logic [15:0] ux_ff, uy_ff, uid_ff;
   logic [31:0] thr_ff;
   logic [40:0] prod_ff;
   logic [32:0] s_ff;
   logic [15:0] rate_ff, tp_ff;
   logic [33:0] sq_rem_ff, sq_root_ff, sq_bit_ff;
   logic [4:0]  iter_ff;
   logic [40:0] den_ff;
   logic [48:0] num_ff, rem_ff;
   logic [56:0] dsh_ff;
   logic [16:0] quot_ff, st_ff, sd_ff, su_ff;
   logic [34:0] acc_ff;
   logic        any_ff;
   logic [15:0] tmax_ff, tmin_ff, dmax_ff, dmin_ff;
   logic [7:0]  umax_ff;
   logic        best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [17:0] best_score_ff;
   logic [15:0] best_dist_ff, best_tp_ff;
   logic        rsp_valid_ff;
   waps_pkg::rsp_type rsp_ff;

   // Combinational helpers.
   logic [15:0] dx, dy, root_sat;
   logic [23:0] mul_a;
   logic [16:0] mul_b;
   logic [8:0]  n_plus_one;
   logic [33:0] sq_sum;
   logic        sq_ge, div_ge;
   logic [18:0] tot19;
   logic [17:0] score18;
   logic [7:0]  users_rd;

   always_comb begin
      if (32'(active_count_ff) > 32'(MAX_APS)) begin
         lim = CNT_W'(MAX_APS);
      end else begin
         lim = CNT_W'(active_count_ff);
      end
   end

   assign rd_idx = idx_ff[IDX_W-1:0];
   assign wr_idx = IDX_W'(req_payload.ap_index);
   assign wr_ok  = 32'(req_payload.ap_index) < 32'(MAX_APS);

   always_ff @(posedge clock) begin
      if (cmd.op == waps_pkg::DP_WRITE && wr_ok) begin
         pos_mem[wr_idx]  <= {req_payload.ap_x, req_payload.ap_y};
         load_mem[wr_idx] <= {req_payload.ap_users, req_payload.ap_utilization};
         rate_mem[wr_idx] <= {req_payload.ap_rate_count, req_payload.ap_inverse_rate_sum};
      end
      if (cmd.op == waps_pkg::DP_P1_STORE) begin
         dist_mem[rd_idx] <= root_sat;
         tp_mem[rd_idx]   <= tp_ff;
      end
      pos_rd_ff  <= pos_mem[rd_idx];
      load_rd_ff <= load_mem[rd_idx];
      rate_rd_ff <= rate_mem[rd_idx];
      dist_rd_ff <= dist_mem[rd_idx];
      tp_rd_ff   <= tp_mem[rd_idx];
   end

   assign dx = (ux_ff > pos_rd_ff[31:16]) ? ux_ff - pos_rd_ff[31:16]
                                           : pos_rd_ff[31:16] - ux_ff;
   assign dy = (uy_ff > pos_rd_ff[15:0]) ? uy_ff - pos_rd_ff[15:0]
                                          : pos_rd_ff[15:0] - uy_ff;
   assign n_plus_one = {1'b0, rate_rd_ff[31:24]} + 9'd1;
   assign users_rd   = load_rd_ff[23:16];
   assign root_sat   = (|sq_root_ff[33:16]) ? 16'hFFFF : sq_root_ff[15:0];
   assign sq_sum     = sq_root_ff + sq_bit_ff;
   assign sq_ge      = sq_rem_ff >= sq_sum;
   assign div_ge     = {8'd0, rem_ff} >= dsh_ff;
   assign tot19      = acc_ff[34:16];
   assign score18    = tot19[18] ? 18'h3FFFF : tot19[17:0];

   // Operand selection for the single shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         waps_pkg::DP_THR: begin
            mul_a = {8'd0, dist_thresh_ff};
            mul_b = {1'b0, dist_thresh_ff};
         end
         waps_pkg::DP_DX: begin
            mul_a = {8'd0, dx};
            mul_b = {1'b0, dx};
         end
         waps_pkg::DP_DY: begin
            mul_a = {8'd0, dy};
            mul_b = {1'b0, dy};
         end
         waps_pkg::DP_TP_MUL1: begin
            mul_a = rate_rd_ff[23:0];
            mul_b = {1'b0, rate_ff};
         end
         waps_pkg::DP_TP_MUL2: begin
            mul_a = {15'd0, n_plus_one};
            mul_b = {1'b0, rate_ff};
         end
         waps_pkg::DP_W_T: begin
            mul_a = {8'd0, w_tput_ff};
            mul_b = st_ff;
         end
         waps_pkg::DP_W_D: begin
            mul_a = {8'd0, w_dist_ff};
            mul_b = sd_ff;
         end
         waps_pkg::DP_W_C: begin
            mul_a = {8'd0, w_chan_ff};
            mul_b = waps_pkg::SCORE_ONE - {1'b0, load_rd_ff[15:0]};
         end
         waps_pkg::DP_W_U: begin
            mul_a = {8'd0, w_users_ff};
            mul_b = su_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= {17'd0, mul_a} * {24'd0, mul_b};
      case (cmd.op)
         waps_pkg::DP_LOAD: begin
            ux_ff         <= req_payload.user_x;
            uy_ff         <= req_payload.user_y;
            uid_ff        <= req_payload.user_id;
            idx_ff        <= '0;
            any_ff        <= 1'b0;
            tmax_ff       <= '0;
            tmin_ff       <= '1;
            dmax_ff       <= '0;
            dmin_ff       <= '1;
            umax_ff       <= '0;
            best_found_ff <= 1'b0;
            best_idx_ff   <= '0;
            best_score_ff <= '0;
            best_dist_ff  <= '0;
            best_tp_ff    <= '0;
         end
         waps_pkg::DP_THR_SAVE: thr_ff <= prod_ff[31:0];
         waps_pkg::DP_DY:       s_ff   <= prod_ff[32:0];
         waps_pkg::DP_SUM:      s_ff   <= s_ff + prod_ff[32:0];
         waps_pkg::DP_TEST: begin
            rate_ff         <= waps_pkg::rate_for(s_ff);
            cand_ff[rd_idx] <= status.cand_now;
         end
         waps_pkg::DP_SQRT_INIT: begin
            sq_rem_ff  <= {1'b0, s_ff};
            sq_root_ff <= '0;
            sq_bit_ff  <= 34'h1_0000_0000;
            iter_ff    <= 5'd16;
         end
         // One result bit per step of the digit-by-digit square root.
         waps_pkg::DP_SQRT_STEP: begin
            if (sq_ge) begin
               sq_rem_ff  <= sq_rem_ff - sq_sum;
               sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_ff <= sq_root_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
            iter_ff   <= iter_ff - 5'd1;
         end
         waps_pkg::DP_TP_MUL2:   den_ff <= prod_ff + 41'h100_0000;
         waps_pkg::DP_TP_NUM:    num_ff <= {prod_ff[24:0], 24'd0};
         waps_pkg::DP_TP_DIRECT: tp_ff  <= status.rate_zero ? rate_ff : 16'hFFFF;
         waps_pkg::DP_TP_DIV_INIT: begin
            rem_ff  <= num_ff;
            dsh_ff  <= {den_ff, 16'd0};
            quot_ff <= '0;
            iter_ff <= 5'd16;
         end
         // Restoring division, one quotient bit per step, divisor shifted down.
         waps_pkg::DP_DIV_STEP: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff[48:0];
            end
            quot_ff <= {quot_ff[15:0], div_ge};
            dsh_ff  <= dsh_ff >> 1;
            iter_ff <= iter_ff - 5'd1;
         end
         waps_pkg::DP_TP_SAVE: tp_ff <= quot_ff[15:0];
         waps_pkg::DP_P1_STORE: begin
            any_ff <= 1'b1;
            if (tp_ff > tmax_ff) tmax_ff <= tp_ff;
            if (tp_ff < tmin_ff) tmin_ff <= tp_ff;
            if (root_sat > dmax_ff) dmax_ff <= root_sat;
            if (root_sat < dmin_ff) dmin_ff <= root_sat;
            if (users_rd > umax_ff) umax_ff <= users_rd;
         end
         waps_pkg::DP_NEXT:      idx_ff <= idx_ff + CNT_W'(1);
         waps_pkg::DP_IDX_CLEAR: idx_ff <= '0;
         waps_pkg::DP_ST_INIT: begin
            rem_ff  <= {17'd0, tp_rd_ff - tmin_ff, 16'd0};
            dsh_ff  <= {25'd0, tmax_ff - tmin_ff, 16'd0};
            quot_ff <= '0;
            iter_ff <= 5'd16;
         end
         waps_pkg::DP_SD_INIT: begin
            rem_ff  <= {17'd0, dist_rd_ff - dmin_ff, 16'd0};
            dsh_ff  <= {25'd0, dmax_ff - dmin_ff, 16'd0};
            quot_ff <= '0;
            iter_ff <= 5'd16;
         end
         waps_pkg::DP_SU_INIT: begin
            rem_ff  <= {25'd0, users_rd, 16'd0};
            dsh_ff  <= {33'd0, umax_ff, 16'd0};
            quot_ff <= '0;
            iter_ff <= 5'd16;
         end
         waps_pkg::DP_ST_SAVE: st_ff <= status.t_flat ? waps_pkg::SCORE_ONE : quot_ff;
         waps_pkg::DP_SD_SAVE: begin
            sd_ff <= status.d_flat ? waps_pkg::SCORE_ONE : waps_pkg::SCORE_ONE - quot_ff;
         end
         waps_pkg::DP_SU_SAVE: begin
            su_ff <= status.u_zero ? waps_pkg::SCORE_ONE : waps_pkg::SCORE_ONE - quot_ff;
         end
         waps_pkg::DP_W_T:   acc_ff <= '0;
         waps_pkg::DP_W_D,
         waps_pkg::DP_W_C,
         waps_pkg::DP_W_U,
         waps_pkg::DP_W_SUM: acc_ff <= acc_ff + {2'd0, prod_ff[32:0]};
         waps_pkg::DP_CMP: begin
            if (!best_found_ff || score18 > best_score_ff) begin
               best_found_ff <= 1'b1;
               best_idx_ff   <= rd_idx;
               best_score_ff <= score18;
               best_dist_ff  <= dist_rd_ff;
               best_tp_ff    <= tp_rd_ff;
            end
         end
         default: ;
      endcase
   end

   // Output register: a finished transaction waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == waps_pkg::DP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == waps_pkg::DP_RESULT) begin
         rsp_ff.found               <= best_found_ff;
         rsp_ff.selected_ap         <= 4'(best_idx_ff);
         rsp_ff.result_user_id      <= uid_ff;
         rsp_ff.best_score          <= best_score_ff;
         rsp_ff.best_distance       <= best_dist_ff;
         rsp_ff.expected_throughput <= best_tp_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      status.at_end    = idx_ff >= lim;
      status.cand_now  = s_ff <= {1'b0, thr_ff};
      status.cand_sel  = cand_ff[rd_idx];
      status.rate_zero = rate_rd_ff[31:24] == 8'd0;
      status.tp_ovf    = {8'd0, num_ff} >= {den_ff, 16'd0};
      status.iter_last = iter_ff == 5'd0;
      status.any       = any_ff;
      status.t_flat    = tmax_ff == tmin_ff;
      status.d_flat    = dmax_ff == dmin_ff;
      status.u_zero    = umax_ff == 8'd0;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ===== src/weighted_access_point_selector_core.sv =====
// Top level of the weighted access point selector.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_ready  waps_pkg::req_type
//   rsp_        out        rsp_valid/rsp_ready  waps_pkg::rsp_type
//   csr_        in         csr_we               csr_index, csr_wdata
//
// The length of a select transaction is set by the bit-serial square root and the
// shared 17-step divider (up to four divisions per candidate).
// Reset is synchronous and active high; entry contents are undefined until written.
// A finished result waits in an output register, and write transactions are taken
// meanwhile; a further select result waits until that register is free.
`timescale 1ns / 1ps
module weighted_access_point_selector_core #(
   parameter int MAX_APS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  waps_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output waps_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [waps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [waps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   waps_pkg::dp_cmd_type    cmd;
   waps_pkg::dp_status_type status;

   waps_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_ready     (req_ready),
      .cmd           (cmd),
      .status        (status)
   );

   waps_datapath #(
      .MAX_APS (MAX_APS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/waps_checker.sv =====
// Port-level checker for the access point selector and its bind statement.
`timescale 1ns / 1ps
`include "weighted_access_point_selector_core_macros.svh"
module waps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input waps_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input waps_pkg::rsp_type rsp_payload
);

   // A stalled result transaction keeps its contents.
   `WAPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Once a select is taken the block is busy with it.
   `WAPS_ASSERT_NEXT(a_busy_after_select, clock, reset, req_valid && req_ready && req_payload.operation == waps_pkg::REQ_SELECT, !req_ready)

   // A write transaction never produces a result.
   `WAPS_ASSERT_NEXT(a_write_silent, clock, reset, req_valid && req_ready && req_payload.operation == waps_pkg::REQ_WRITE && !rsp_valid, !rsp_valid)

   // With no candidate the selected index, score, distance and throughput are all zero.
   `WAPS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_payload.found, rsp_payload.selected_ap == 4'd0 && rsp_payload.best_score == 18'd0 && rsp_payload.best_distance == 16'd0 && rsp_payload.expected_throughput == 16'd0)

endmodule

bind weighted_access_point_selector_core waps_checker u_waps_checker (.*);

// ===== tb/tb_weighted_access_point_selector_core.sv =====
// Self-checking testbench of the weighted access point selector core.
`timescale 1ns / 1ps
module tb_weighted_access_point_selector_core;

   localparam int TABLE_DEPTH    = 16;
   localparam int STALL_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 20;
   localparam logic [waps_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [waps_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   waps_pkg::req_type                req_payload;
   logic                             rsp_valid;
   logic                             rsp_ready;
   waps_pkg::rsp_type                rsp_payload;
   logic                             csr_we;
   logic [waps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [waps_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // Shadow copy of the entry table and the registers.
   logic [15:0] ap_x_tab [TABLE_DEPTH];
   logic [15:0] ap_y_tab [TABLE_DEPTH];
   logic [7:0]  users_tab [TABLE_DEPTH];
   logic [15:0] util_tab [TABLE_DEPTH];
   logic [7:0]  rate_count_tab [TABLE_DEPTH];
   logic [23:0] inv_sum_tab [TABLE_DEPTH];
   logic [4:0]  active_count;
   logic [15:0] dist_limit;
   logic [15:0] w_tput;
   logic [15:0] w_dist;
   logic [15:0] w_chan;
   logic [15:0] w_users;

   waps_pkg::rsp_type selections_due [$];
   int          error_count;
   int          idle_cycles;
   int          send_quiet_left;
   int          recv_quiet_left;
   logic [15:0] centre_x;
   logic [15:0] centre_y;

   weighted_access_point_selector_core #(
      .MAX_APS(TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitval;
      root   = 0;
      bitval = 64'd1 << 62;
      while (bitval > v) bitval >>= 2;
      while (bitval != 0) begin
         if (v >= root + bitval) begin
            v    = v - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root = root >> 1;
         end
         bitval >>= 2;
      end
      return root;
   endfunction

   // Link rate in Mbps Q8.8 from the squared distance; steps at 5, 10, 15, 20 and 25 m.
   function automatic longint unsigned link_rate(input longint unsigned sq);
      longint unsigned bounds [5];
      longint unsigned rates [6];
      bounds = '{1280, 2560, 3840, 5120, 6400};
      rates  = '{38400, 33280, 25600, 16640, 7680, 1664};
      for (int k = 0; k < 5; k++) begin
         if (sq < bounds[k] * bounds[k]) return rates[k];
      end
      return rates[5];
   endfunction

   // Harmonic mean of the existing rates together with the new link rate.
   function automatic longint unsigned harmonic_tput(input int idx, input longint unsigned rate);
      longint unsigned n;
      longint unsigned q;
      n = 64'(rate_count_tab[idx]);
      if (n == 0) return rate;
      q = ((n + 1) * rate << 24) / (64'(inv_sum_tab[idx]) * rate + (64'd1 << 24));
      return (q > 65535) ? 65535 : q;
   endfunction

   function automatic waps_pkg::rsp_type predict_selection(input waps_pkg::req_type r);
      waps_pkg::rsp_type o;
      longint unsigned tp [TABLE_DEPTH];
      longint unsigned dd [TABLE_DEPTH];
      bit              cand [TABLE_DEPTH];
      int              lim;
      int              best_idx;
      longint unsigned dx, dy, sq, thr, sq_root;
      longint unsigned tmax, tmin, dmax, dmin, umax;
      longint unsigned st, sd, sc, su, total, best;
      o = '0;
      o.result_user_id = r.user_id;
      lim  = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
      thr  = 64'(dist_limit) * 64'(dist_limit);
      tmax = 0;
      tmin = '1;
      dmax = 0;
      dmin = '1;
      umax = 0;
      best = 0;
      best_idx = 0;
      for (int i = 0; i < lim; i++) begin
         dx = (r.user_x > ap_x_tab[i]) ? 64'(r.user_x - ap_x_tab[i])
                                       : 64'(ap_x_tab[i] - r.user_x);
         dy = (r.user_y > ap_y_tab[i]) ? 64'(r.user_y - ap_y_tab[i])
                                       : 64'(ap_y_tab[i] - r.user_y);
         sq = dx * dx + dy * dy;
         cand[i] = (sq <= thr);
         if (!cand[i]) continue;
         sq_root = int_sqrt(sq);
         dd[i] = (sq_root > 65535) ? 65535 : sq_root;
         tp[i] = harmonic_tput(i, link_rate(sq));
         if (tp[i] > tmax) tmax = tp[i];
         if (tp[i] < tmin) tmin = tp[i];
         if (dd[i] > dmax) dmax = dd[i];
         if (dd[i] < dmin) dmin = dd[i];
         if (64'(users_tab[i]) > umax) umax = 64'(users_tab[i]);
      end
      for (int i = 0; i < lim; i++) begin
         if (!cand[i]) continue;
         st = (tmax == tmin) ? 64'd65536 : ((tp[i] - tmin) << 16) / (tmax - tmin);
         sd = (dmax == dmin) ? 64'd65536 : 64'd65536 - ((dd[i] - dmin) << 16) / (dmax - dmin);
         sc = 64'd65536 - 64'(util_tab[i]);
         su = (umax == 0) ? 64'd65536 : 64'd65536 - (64'(users_tab[i]) << 16) / umax;
         total = (64'(w_tput) * st + 64'(w_dist) * sd + 64'(w_chan) * sc
                  + 64'(w_users) * su) >> 16;
         if (total > 262143) total = 262143;
         if (!o.found || total > best) begin
            o.found  = 1'b1;
            best     = total;
            best_idx = i;
         end
      end
      if (o.found) begin
         o.selected_ap         = best_idx[3:0];
         o.best_score          = best[17:0];
         o.best_distance       = dd[best_idx][15:0];
         o.expected_throughput = tp[best_idx][15:0];
      end
      return o;
   endfunction

   // Sends one request; a write updates the shadow table, a select queues its result.
   task automatic send_request(input waps_pkg::req_type r);
      int gap;
      if (send_quiet_left > 0) begin
         send_quiet_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 16);
         if ($urandom_range(0, 19) == 0) send_quiet_left = $urandom_range(10, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      if (r.operation == waps_pkg::REQ_WRITE) begin
         ap_x_tab[r.ap_index]       = r.ap_x;
         ap_y_tab[r.ap_index]       = r.ap_y;
         users_tab[r.ap_index]      = r.ap_users;
         util_tab[r.ap_index]       = r.ap_utilization;
         rate_count_tab[r.ap_index] = r.ap_rate_count;
         inv_sum_tab[r.ap_index]    = r.ap_inverse_rate_sum;
      end else begin
         selections_due.insert(selections_due.size(), predict_selection(r));
      end
   endtask

   // Lets the block finish all outstanding work so that registers may be written.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (selections_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [waps_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         waps_pkg::CSR_ACTIVE_COUNT: active_count = value[4:0];
         waps_pkg::CSR_DIST_THRESH:  dist_limit   = value;
         waps_pkg::CSR_WEIGHT_TPUT:  w_tput       = value;
         waps_pkg::CSR_WEIGHT_DIST:  w_dist       = value;
         waps_pkg::CSR_WEIGHT_CHAN:  w_chan       = value;
         waps_pkg::CSR_WEIGHT_USERS: w_users      = value;
         default: ;
      endcase
   endtask

   function automatic waps_pkg::req_type entry_write(input logic [3:0] idx,
                                                     input logic [15:0] x,
                                                     input logic [15:0] y,
                                                     input logic [7:0] users,
                                                     input logic [15:0] util,
                                                     input logic [7:0] n,
                                                     input logic [23:0] inv_sum);
      waps_pkg::req_type r;
      r = '0;
      r.operation           = waps_pkg::REQ_WRITE;
      r.ap_index            = idx;
      r.ap_x                = x;
      r.ap_y                = y;
      r.ap_users            = users;
      r.ap_utilization      = util;
      r.ap_rate_count       = n;
      r.ap_inverse_rate_sum = inv_sum;
      r.user_x              = 16'($urandom_range(0, 65535));
      r.user_y              = 16'($urandom_range(0, 65535));
      r.user_id             = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic waps_pkg::req_type user_select(input logic [15:0] x,
                                                     input logic [15:0] y,
                                                     input logic [15:0] id);
      waps_pkg::req_type r;
      r = '0;
      r.operation           = waps_pkg::REQ_SELECT;
      r.ap_index            = 4'($urandom_range(0, 15));
      r.ap_x                = 16'($urandom_range(0, 65535));
      r.ap_y                = 16'($urandom_range(0, 65535));
      r.ap_users            = 8'($urandom_range(0, 255));
      r.ap_utilization      = 16'($urandom_range(0, 65535));
      r.ap_rate_count       = 8'($urandom_range(0, 255));
      r.ap_inverse_rate_sum = 24'($urandom_range(0, 24'hFFFFFF));
      r.user_x              = x;
      r.user_y              = y;
      r.user_id             = id;
      return r;
   endfunction

   function automatic logic [15:0] near_centre(input logic [15:0] c);
      return c + 16'($urandom_range(0, 16000)) - 16'd8000;
   endfunction

   // Every entry is written once so that no select ever reads an unwritten entry.
   task automatic test_table_fill();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_request(entry_write(i[3:0], 16'h8000 + 16'(i * 300), 16'h8000, 8'(i), 16'(i * 1000),
                                  8'(i % 3), 24'(i * 5000)));
      end
      // Reset values of the registers are in force here.
      send_request(user_select(16'h8000, 16'h8000, 16'h1234));
      send_request(user_select(16'h8400, 16'h8000, 16'h4321));
      wait_until_idle();
   endtask

   task automatic test_directed();
      write_register(waps_pkg::CSR_ACTIVE_COUNT, 16'd4);
      write_register(waps_pkg::CSR_DIST_THRESH, 16'hFFFF);
      // User on top of an entry, two identical entries for a tie, a saturating throughput.
      send_request(entry_write(4'd0, 16'h1000, 16'h1000, 8'd0, 16'd0, 8'd255, 24'd0));
      send_request(entry_write(4'd1, 16'h1000, 16'h1000, 8'd0, 16'd0, 8'd255, 24'd0));
      send_request(entry_write(4'd2, 16'h2000, 16'h1000, 8'd0, 16'hFFFF, 8'd0, 24'hFFFFFF));
      send_request(entry_write(4'd3, 16'h1000, 16'h1500, 8'd0, 16'd0, 8'd1, 24'hFFFFFF));
      send_request(user_select(16'h1000, 16'h1000, 16'd0));
      send_request(user_select(16'h1A00, 16'h1000, 16'hFFFF));
      send_request(user_select(16'h0000, 16'h0000, 16'hA5A5));
      send_request(entry_write(4'd15, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 8'd255, 24'hFFFFFF));
      send_request(entry_write(4'd14, 16'h0000, 16'h0000, 8'd255, 16'd0, 8'd0, 24'd0));
      wait_until_idle();
      // Corner-to-corner user, all sixteen entries active.
      write_register(waps_pkg::CSR_ACTIVE_COUNT, 16'd16);
      send_request(user_select(16'h0000, 16'h0000, 16'h5A5A));
      send_request(user_select(16'hFFFF, 16'hFFFF, 16'h0F0F));
      wait_until_idle();
      // A zero limit leaves only coincident entries; the user far away finds nothing.
      write_register(waps_pkg::CSR_DIST_THRESH, 16'd0);
      send_request(user_select(16'h1000, 16'h1000, 16'h0001));
      send_request(user_select(16'h7777, 16'h7777, 16'h0002));
      wait_until_idle();
      // A count of zero gives no candidates and one above the table size is clipped.
      write_register(waps_pkg::CSR_DIST_THRESH, 16'hFFFF);
      write_register(waps_pkg::CSR_ACTIVE_COUNT, 16'd0);
      send_request(user_select(16'h1000, 16'h1000, 16'h0003));
      wait_until_idle();
      write_register(waps_pkg::CSR_ACTIVE_COUNT, 16'd31);
      write_register(waps_pkg::CSR_WEIGHT_TPUT, 16'hFFFF);
      write_register(waps_pkg::CSR_WEIGHT_DIST, 16'hFFFF);
      write_register(waps_pkg::CSR_WEIGHT_CHAN, 16'hFFFF);
      write_register(waps_pkg::CSR_WEIGHT_USERS, 16'hFFFF);
      // Writes to indexes past the register list must change nothing.
      write_register(CSR_SPARE_A, 16'd1);
      write_register(CSR_SPARE_B, 16'd0);
      send_request(user_select(16'h1000, 16'h1000, 16'h0004));
      send_request(user_select(16'h8000, 16'h8000, 16'h0005));
      wait_until_idle();
      write_register(waps_pkg::CSR_WEIGHT_TPUT, 16'd0);
      write_register(waps_pkg::CSR_WEIGHT_DIST, 16'd0);
      write_register(waps_pkg::CSR_WEIGHT_CHAN, 16'd0);
      write_register(waps_pkg::CSR_WEIGHT_USERS, 16'd0);
      send_request(user_select(16'h1000, 16'h1000, 16'h0006));
      wait_until_idle();
   endtask

   // One random setting of the registers, then a stream of entry updates and user selects
   // mostly placed around one spot so that several entries fall within the limit.
   task automatic test_random_phase(input int n_items);
      int                pick;
      waps_pkg::req_type r;
      pick = $urandom_range(0, 9);
      write_register(waps_pkg::CSR_ACTIVE_COUNT,
                     (pick == 0) ? 16'd16 : (pick == 1) ? 16'($urandom_range(0, 31))
                                          : 16'($urandom_range(1, 8)));
      pick = $urandom_range(0, 9);
      write_register(waps_pkg::CSR_DIST_THRESH,
                     (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0
                                            : 16'($urandom_range(1000, 13000)));
      write_register(waps_pkg::CSR_WEIGHT_TPUT,
                     ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      write_register(waps_pkg::CSR_WEIGHT_DIST, 16'($urandom_range(0, 65535)));
      write_register(waps_pkg::CSR_WEIGHT_CHAN, 16'($urandom_range(0, 65535)));
      write_register(waps_pkg::CSR_WEIGHT_USERS,
                     ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
      centre_x = 16'($urandom_range(8000, 57535));
      centre_y = 16'($urandom_range(8000, 57535));
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            r = entry_write(4'($urandom_range(0, 15)), near_centre(centre_x),
                            near_centre(centre_y),
                            ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 20)),
                            24'($urandom_range(0, 24'h3FFFF)));
         end else if (pick < 90) begin
            r = user_select(near_centre(centre_x), near_centre(centre_y),
                            16'($urandom_range(0, 65535)));
         end else begin
            r = entry_write(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                            24'($urandom_range(0, 24'hFFFFFF)));
            if ($urandom_range(0, 1) == 1) begin
               r.operation = waps_pkg::REQ_SELECT;
            end
         end
         send_request(r);
      end
      wait_until_idle();
   endtask

   // Result side: random stalls of the ready, with stretches of none.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      recv_quiet_left = 0;
      forever begin
         if (recv_quiet_left > 0) begin
            recv_quiet_left--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 16);
            if ($urandom_range(0, 19) == 0) recv_quiet_left = $urandom_range(5, 20);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Each result transaction is checked against the oldest outstanding selection.
   always @(posedge clock) begin
      waps_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (selections_due.size() == 0) begin
            $error("result transaction with no select outstanding");
            error_count++;
         end else begin
            exp_rsp = selections_due.pop_front();
            if (rsp_payload.found !== exp_rsp.found) begin
               $error("found: expected %0d, got %0d", exp_rsp.found, rsp_payload.found);
               error_count++;
            end
            if (rsp_payload.selected_ap !== exp_rsp.selected_ap) begin
               $error("selected_ap: expected %0d, got %0d",
                      exp_rsp.selected_ap, rsp_payload.selected_ap);
               error_count++;
            end
            if (rsp_payload.result_user_id !== exp_rsp.result_user_id) begin
               $error("result_user_id: expected %0d, got %0d",
                      exp_rsp.result_user_id, rsp_payload.result_user_id);
               error_count++;
            end
            if (rsp_payload.best_score !== exp_rsp.best_score) begin
               $error("best_score: expected %0d, got %0d",
                      exp_rsp.best_score, rsp_payload.best_score);
               error_count++;
            end
            if (rsp_payload.best_distance !== exp_rsp.best_distance) begin
               $error("best_distance: expected %0d, got %0d",
                      exp_rsp.best_distance, rsp_payload.best_distance);
               error_count++;
            end
            if (rsp_payload.expected_throughput !== exp_rsp.expected_throughput) begin
               $error("expected_throughput: expected %0d, got %0d",
                      exp_rsp.expected_throughput, rsp_payload.expected_throughput);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction of any kind takes place.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      error_count     = 0;
      idle_cycles     = 0;
      send_quiet_left = 0;
      active_count    = waps_pkg::RST_ACTIVE_COUNT;
      dist_limit      = waps_pkg::RST_DIST_THRESH;
      w_tput          = waps_pkg::RST_WEIGHT_TPUT;
      w_dist          = waps_pkg::RST_WEIGHT_DIST;
      w_chan          = waps_pkg::RST_WEIGHT_CHAN;
      w_users         = waps_pkg::RST_WEIGHT_USERS;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_fill();
      test_directed();
      for (int p = 0; p < 10; p++) test_random_phase(150);

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/waps_pkg.sv
src/waps_controller.sv
src/waps_datapath.sv
src/weighted_access_point_selector_core.sv
src/waps_checker.sv
tb/tb_weighted_access_point_selector_core.sv
